FILE: hdl/buft_pkg.sv
// shared types and constants for the bus uart transmit framer
`default_nettype none
package buft_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 263;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [7:0]  START_OPCODE_RST   = 8'd128;
  localparam logic [7:0]  END_OPCODE_RST     = 8'd64;
  localparam logic [7:0]  OFFSET_OPCODE_RST  = 8'd8;
  localparam logic [7:0]  ACK_OPCODE_RST     = 8'd16;
  localparam logic        COMPACT_MODE_RST   = 1'b0;
  localparam logic [15:0] WATCHDOG_LIMIT_RST = 16'd60000;

  // frames above this length are dropped in compact mode
  localparam logic [8:0]  COMPACT_MAX_LEN    = 9'd64;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_WAIT = 2'd2,
    MODE_DROP = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CMD_BYTE    = 3'd0,
    CMD_CONFIRM = 3'd1,
    CMD_TICK    = 3'd2,
    CMD_ACK     = 3'd3,
    CMD_RESET   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_START_OPCODE   = 3'd0,
    REG_END_OPCODE     = 3'd1,
    REG_OFFSET_OPCODE  = 3'd2,
    REG_ACK_OPCODE     = 3'd3,
    REG_COMPACT_MODE   = 3'd4,
    REG_WATCHDOG_LIMIT = 3'd5
  } reg_idx_t;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [1:0] KIND_REFUSED = 2'd2;

  // one accepted item expanded into up to four results
  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
    logic            awaiting;
  } job_t;

  typedef struct packed {
    logic                   full;
    logic [QUEUE_CNT_W-1:0] count;
  } q_status_t;

endpackage
`default_nettype wire

FILE: hdl/buft_front.sv
// front part: configuration registers, framing state and item classification
`default_nettype none
module buft_front #(
  parameter int unsigned MAX_FRAME_BYTES = buft_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [2:0]      command,
  input  wire logic [7:0]      data_byte,
  input  wire logic [8:0]      frame_length,
  input  wire logic [2:0]      ack_type,
  input  wire logic            line_free,
  input  wire logic            cfg_write,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [15:0]     cfg_data,
  output logic                 job_valid,
  output buft_pkg::job_t       job
);

  localparam logic [8:0] LEN_MAX = 9'(MAX_FRAME_BYTES);

  logic [7:0]  start_opcode;
  logic [7:0]  end_opcode;
  logic [7:0]  offset_opcode;
  logic [7:0]  ack_opcode;
  logic        compact_mode;
  logic [15:0] watchdog_limit;

  buft_pkg::mode_t mode, mode_next;
  logic [8:0]  byte_position, byte_position_next;
  logic [8:0]  length_in_use, length_in_use_next;
  logic [7:0]  pending_ack, pending_ack_next;
  logic [15:0] wait_counter, wait_counter_next;

  logic [8:0]       len_clip;
  logic [8:0]       len_cur;
  logic [8:0]       pos_cur;
  buft_pkg::mode_t  mode_cur;
  logic [9:0]       pos_inc;
  logic             is_last;
  logic [15:0]      cnt_sat;
  logic             timeout;
  logic [7:0]       ack_code;
  logic [7:0]       pos_code;
  logic [7:0]       off_code;
  logic             has_off;
  logic             has_ack;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_opcode   <= buft_pkg::START_OPCODE_RST;
      end_opcode     <= buft_pkg::END_OPCODE_RST;
      offset_opcode  <= buft_pkg::OFFSET_OPCODE_RST;
      ack_opcode     <= buft_pkg::ACK_OPCODE_RST;
      compact_mode   <= buft_pkg::COMPACT_MODE_RST;
      watchdog_limit <= buft_pkg::WATCHDOG_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (buft_pkg::reg_idx_t'(cfg_index))
        buft_pkg::REG_START_OPCODE:   start_opcode   <= cfg_data[7:0];
        buft_pkg::REG_END_OPCODE:     end_opcode     <= cfg_data[7:0];
        buft_pkg::REG_OFFSET_OPCODE:  offset_opcode  <= cfg_data[7:0];
        buft_pkg::REG_ACK_OPCODE:     ack_opcode     <= cfg_data[7:0];
        buft_pkg::REG_COMPACT_MODE:   compact_mode   <= cfg_data[0];
        buft_pkg::REG_WATCHDOG_LIMIT: watchdog_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= buft_pkg::MODE_IDLE;
      byte_position <= '0;
      length_in_use <= '0;
      pending_ack   <= '0;
      wait_counter  <= '0;
    end else begin
      mode          <= mode_next;
      byte_position <= byte_position_next;
      length_in_use <= length_in_use_next;
      pending_ack   <= pending_ack_next;
      wait_counter  <= wait_counter_next;
    end
  end

  // position and length seen by a frame byte; the first byte of a frame opens it
  always_comb begin
    if (frame_length == 9'd0) begin
      len_clip = 9'd1;
    end else if (frame_length > LEN_MAX) begin
      len_clip = LEN_MAX;
    end else begin
      len_clip = frame_length;
    end
    if (mode == buft_pkg::MODE_IDLE) begin
      len_cur  = len_clip;
      pos_cur  = '0;
      mode_cur = (compact_mode && (len_clip > buft_pkg::COMPACT_MAX_LEN)) ?
                 buft_pkg::MODE_DROP : buft_pkg::MODE_SEND;
    end else begin
      len_cur  = length_in_use;
      pos_cur  = byte_position;
      mode_cur = mode;
    end
    pos_inc  = {1'b0, pos_cur} + 10'd1;
    is_last  = pos_inc >= {1'b0, len_cur};
    cnt_sat  = (wait_counter == 16'hFFFF) ? wait_counter : wait_counter + 16'd1;
    timeout  = cnt_sat >= watchdog_limit;
    ack_code = ack_opcode | {5'b0, ack_type};
    pos_code = (is_last ? end_opcode : start_opcode) | {2'b0, pos_cur[5:0]};
    off_code = offset_opcode | {5'b0, pos_cur[8:6]};
    has_off  = pos_cur[8:6] != 3'd0;
    has_ack  = pending_ack != 8'd0;
  end

  // next state
  always_comb begin
    mode_next          = mode;
    byte_position_next = byte_position;
    length_in_use_next = length_in_use;
    pending_ack_next   = pending_ack;
    wait_counter_next  = wait_counter;
    if (accept) begin
      unique case (buft_pkg::cmd_t'(command))
        buft_pkg::CMD_BYTE: begin
          if (mode != buft_pkg::MODE_WAIT) begin
            length_in_use_next = len_cur;
            if (mode_cur == buft_pkg::MODE_DROP) begin
              mode_next          = is_last ? buft_pkg::MODE_IDLE : buft_pkg::MODE_DROP;
              byte_position_next = is_last ? 9'd0 : pos_inc[8:0];
            end else begin
              if (is_last) begin
                mode_next          = buft_pkg::MODE_WAIT;
                byte_position_next = '0;
                wait_counter_next  = '0;
              end else begin
                mode_next          = buft_pkg::MODE_SEND;
                byte_position_next = pos_inc[8:0];
              end
              pending_ack_next = '0;
            end
          end
        end
        buft_pkg::CMD_CONFIRM: begin
          if (mode == buft_pkg::MODE_WAIT) begin
            mode_next = buft_pkg::MODE_IDLE;
          end
        end
        buft_pkg::CMD_TICK: begin
          if (mode == buft_pkg::MODE_WAIT) begin
            if (timeout) begin
              mode_next          = buft_pkg::MODE_IDLE;
              byte_position_next = '0;
              wait_counter_next  = '0;
            end else begin
              wait_counter_next = cnt_sat;
            end
          end
        end
        buft_pkg::CMD_ACK: begin
          if (!line_free) begin
            pending_ack_next = ack_code;
          end
        end
        buft_pkg::CMD_RESET: begin
          mode_next          = buft_pkg::MODE_IDLE;
          byte_position_next = '0;
          length_in_use_next = '0;
          wait_counter_next  = '0;
        end
        default: ;
      endcase
    end
  end

  // job for the back part
  always_comb begin
    job_valid    = 1'b0;
    job          = '0;
    job.awaiting = mode_next == buft_pkg::MODE_WAIT;
    if (accept) begin
      unique case (buft_pkg::cmd_t'(command))
        buft_pkg::CMD_BYTE: begin
          if (mode == buft_pkg::MODE_WAIT) begin
            job_valid = 1'b1;
            job.kind  = buft_pkg::KIND_REFUSED;
          end else if (mode_cur == buft_pkg::MODE_SEND) begin
            job_valid    = 1'b1;
            job.kind     = buft_pkg::KIND_BYTE;
            job.last_idx = 2'd1 + {1'b0, has_off} + {1'b0, has_ack};
            if (has_off) begin
              job.bytes[0] = off_code;
              job.bytes[1] = pos_code;
              job.bytes[2] = data_byte;
              job.bytes[3] = pending_ack;
            end else begin
              job.bytes[0] = pos_code;
              job.bytes[1] = data_byte;
              job.bytes[2] = pending_ack;
            end
          end
        end
        buft_pkg::CMD_TICK: begin
          if (mode == buft_pkg::MODE_WAIT && timeout) begin
            job_valid = 1'b1;
            job.kind  = buft_pkg::KIND_TIMEOUT;
          end
        end
        buft_pkg::CMD_ACK: begin
          if (line_free) begin
            job_valid    = 1'b1;
            job.kind     = buft_pkg::KIND_BYTE;
            job.bytes[0] = ack_code;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/buft_queue.sv
// short job queue between the front and back parts
`default_nettype none
module buft_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire buft_pkg::job_t   push_job,
  input  wire logic             pop,
  output logic                  head_valid,
  output buft_pkg::job_t        head_job,
  output buft_pkg::q_status_t   status
);

  localparam logic [buft_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
    buft_pkg::QUEUE_CNT_W'(buft_pkg::QUEUE_DEPTH);
  localparam logic [buft_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    buft_pkg::QUEUE_PTR_W'(buft_pkg::QUEUE_DEPTH - 1);

  buft_pkg::job_t entries [buft_pkg::QUEUE_DEPTH];
  logic [buft_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [buft_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [buft_pkg::QUEUE_CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign head_valid   = count != '0;
  assign head_job     = entries[rd_ptr];
  assign status.count = count;
  assign status.full  = count == DEPTH_CNT;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/buft_back.sv
// back part: holds the current job and hands out its results one per pop
`default_nettype none
module buft_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire buft_pkg::job_t head_job,
  output logic                head_pop,
  input  wire logic           pop,
  output logic                empty,
  output logic [1:0]          kind,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                awaiting_confirm
);

  buft_pkg::job_t cur;
  logic           cur_valid;
  logic [1:0]     idx;
  logic           taken;
  logic           finish;

  assign taken    = pop && cur_valid;
  assign finish   = taken && (idx == cur.last_idx);
  assign head_pop = head_valid && (!cur_valid || finish);

  assign empty            = !cur_valid;
  assign kind             = cur.kind;
  assign out_byte         = cur.bytes[idx];
  assign run_last         = idx == cur.last_idx;
  assign awaiting_confirm = cur.awaiting;

  always_ff @(posedge clk) begin
    if (head_pop) begin
      cur <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (head_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (finish) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (taken) begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bus_uart_frame_transmit_framer.sv
// path: an accepted item's job is queued, then held in the back part for output
// throughput: one item per cycle at the input while the two-entry job queue has room
// results leave at one per cycle while pop is held; a frame byte gives two to four,
// so the back end, not the input, limits the sustained rate of frame bytes
// reset: synchronous rst clears state, queue and output; registers take their defaults
`default_nettype none
module bus_uart_frame_transmit_framer #(
  parameter int unsigned MAX_FRAME_BYTES = buft_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  command,
  input  wire logic [7:0]  data_byte,
  input  wire logic [8:0]  frame_length,
  input  wire logic [2:0]  ack_type,
  input  wire logic        line_free,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             awaiting_confirm,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic                accept;
  logic                job_valid;
  buft_pkg::job_t      job;
  logic                head_valid;
  buft_pkg::job_t      head_job;
  logic                head_pop;
  buft_pkg::q_status_t q_status;

  assign full   = q_status.full;
  assign accept = push && !full;

  buft_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (command),
    .data_byte    (data_byte),
    .frame_length (frame_length),
    .ack_type     (ack_type),
    .line_free    (line_free),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .job_valid    (job_valid),
    .job          (job)
  );

  buft_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_valid),
    .push_job   (job),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .status     (q_status)
  );

  buft_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .head_pop         (head_pop),
    .pop              (pop),
    .empty            (empty),
    .kind             (kind),
    .out_byte         (out_byte),
    .run_last         (run_last),
    .awaiting_confirm (awaiting_confirm)
  );

`ifndef SYNTHESIS
  // a queued job reaches the output register on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (q_status.count != '0 && empty) |=> !empty)
    else $error("queued job did not reach the output");

  // timeout and refusal are single results with a zero byte
  assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != buft_pkg::KIND_BYTE) |-> (run_last && out_byte == 8'd0))
    else $error("status result is not a single zero item");

  // an item that would overfill the queue is never taken
  assert property (@(posedge clk) disable iff (rst)
    (job_valid && !head_pop) |-> !q_status.full)
    else $error("job pushed into a full queue");
`endif

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// self-checking testbench for the bus uart transmit framer
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data;
    logic [8:0] len;
    logic [2:0] ack;
    logic       free;
  } uart_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       run_last;
    logic       awaiting;
  } uart_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic        run_last, awaiting_confirm;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  uart_item_t  drive_item = '0;

  bus_uart_frame_transmit_framer dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .command          (drive_item.cmd),
    .data_byte        (drive_item.data),
    .frame_length     (drive_item.len),
    .ack_type         (drive_item.ack),
    .line_free        (drive_item.free),
    .empty            (empty),
    .pop              (pop),
    .kind             (kind),
    .out_byte         (out_byte),
    .run_last         (run_last),
    .awaiting_confirm (awaiting_confirm),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  uart_item_t   pending_items[$];
  uart_result_t expected_results[$];
  uart_result_t step_out[$];

  // framer state as the testbench sees it
  buft_pkg::mode_t fr_mode;
  logic [8:0]  fr_pos, fr_len;
  logic [7:0]  fr_pending_ack;
  logic [15:0] fr_wait;
  logic [7:0]  reg_start, reg_end, reg_offset, reg_ack;
  logic        reg_compact;
  logic [15:0] reg_watchdog;

  int  items_queued = 0;
  int  items_accepted = 0;
  int  results_checked = 0;
  int  timeouts_seen = 0;
  int  refusals_seen = 0;
  int  settings_used = 1;
  int  mismatches = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  logic calm = 1'b0;
  logic hold_results = 1'b0;

  function automatic void emit(logic [1:0] k, logic [7:0] b);
    step_out.push_back('{k, b, 1'b0, 1'b0});
  endfunction

  function automatic void predict_framer(uart_item_t it);
    logic [8:0]   len;
    logic [8:0]   p;
    logic         is_last;
    logic [7:0]   code;
    uart_result_t r;
    step_out.delete();
    case (it.cmd)
      buft_pkg::CMD_BYTE: begin
        if (fr_mode == buft_pkg::MODE_WAIT) begin
          emit(buft_pkg::KIND_REFUSED, 8'h00);
        end else begin
          if (fr_mode == buft_pkg::MODE_IDLE) begin
            len = it.len;
            if (len == 0) len = 9'd1;
            if (len > buft_pkg::MAX_FRAME_BYTES_DEF) len = 9'(buft_pkg::MAX_FRAME_BYTES_DEF);
            fr_len = len;
            fr_pos = '0;
            fr_mode = (reg_compact && len > buft_pkg::COMPACT_MAX_LEN) ?
                      buft_pkg::MODE_DROP : buft_pkg::MODE_SEND;
          end
          p = fr_pos;
          is_last = (int'(p) + 1 >= int'(fr_len));
          if (fr_mode == buft_pkg::MODE_DROP) begin
            fr_pos = p + 9'd1;
            if (is_last) begin
              fr_mode = buft_pkg::MODE_IDLE;
              fr_pos = '0;
            end
          end else begin
            if (p >= 9'd64) emit(buft_pkg::KIND_BYTE, reg_offset | 8'(p >> 6));
            emit(buft_pkg::KIND_BYTE, (is_last ? reg_end : reg_start) | {2'b00, p[5:0]});
            emit(buft_pkg::KIND_BYTE, it.data);
            if (is_last) begin
              fr_mode = buft_pkg::MODE_WAIT;
              fr_wait = '0;
              fr_pos = '0;
            end else begin
              fr_pos = p + 9'd1;
            end
            // a cached acknowledge rides behind the frame byte
            if (fr_pending_ack != 0) begin
              emit(buft_pkg::KIND_BYTE, fr_pending_ack);
              fr_pending_ack = '0;
            end
          end
        end
      end
      buft_pkg::CMD_CONFIRM: if (fr_mode == buft_pkg::MODE_WAIT) fr_mode = buft_pkg::MODE_IDLE;
      buft_pkg::CMD_TICK: begin
        if (fr_mode == buft_pkg::MODE_WAIT) begin
          if (fr_wait != 16'hFFFF) fr_wait = fr_wait + 16'd1;
          if (fr_wait >= reg_watchdog) begin
            fr_mode = buft_pkg::MODE_IDLE;
            fr_pos = '0;
            fr_wait = '0;
            emit(buft_pkg::KIND_TIMEOUT, 8'h00);
          end
        end
      end
      buft_pkg::CMD_ACK: begin
        code = reg_ack | {5'b00000, it.ack};
        if (it.free) emit(buft_pkg::KIND_BYTE, code);
        else fr_pending_ack = code;
      end
      buft_pkg::CMD_RESET: begin
        fr_mode = buft_pkg::MODE_IDLE;
        fr_pos = '0;
        fr_len = '0;
        fr_wait = '0;
      end
      default: ;
    endcase
    foreach (step_out[i]) begin
      r = step_out[i];
      r.run_last = (i == step_out.size() - 1);
      r.awaiting = (fr_mode == buft_pkg::MODE_WAIT);
      expected_results.push_back(r);
    end
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk) begin : driver
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_framer(drive_item);
        items_accepted++;
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_items.size() == 0) begin
          push <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 12);
          push <= 1'b0;
        end else begin
          drive_item <= pending_items.pop_front();
          push <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    uart_result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b await %0b",
                                    kind, out_byte, run_last, awaiting_confirm));
        end else begin
          want = expected_results.pop_front();
          if (kind !== want.kind || out_byte !== want.out_byte ||
              run_last !== want.run_last || awaiting_confirm !== want.awaiting)
            report_mismatch($sformatf(
              "result %0d: want kind %0d byte %02h last %0b await %0b, got %0d %02h %0b %0b",
              results_checked, want.kind, want.out_byte, want.run_last, want.awaiting,
              kind, out_byte, run_last, awaiting_confirm));
          if (want.kind == buft_pkg::KIND_TIMEOUT) timeouts_seen++;
          if (want.kind == buft_pkg::KIND_REFUSED) refusals_seen++;
        end
        results_checked++;
      end
      if (hold_results) begin
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(0, 12);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // long receiver stall while items keep coming, so the input backs up
  initial begin : receiver_hold
    wait (items_accepted >= 40);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (400) @(posedge clk);
    hold_results <= 1'b0;
  end

  initial begin : run_limit
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic add_item(logic [2:0] cmd, logic [7:0] data, logic [8:0] len,
                          logic [2:0] ack, logic free);
    pending_items.push_back('{cmd, data, len, ack, free});
    items_queued++;
  endtask

  // a frame of random bytes; later bytes carry a junk length that must be ignored
  task automatic add_frame(int len, logic [8:0] first_len);
    for (int k = 0; k < len; k++) begin
      add_item(buft_pkg::CMD_BYTE, 8'($urandom_range(0, 255)),
               (k == 0) ? first_len : 9'($urandom_range(0, 511)),
               3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      if (k > 0 && $urandom_range(0, 5) == 0)
        add_item(buft_pkg::CMD_ACK, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic add_simple(logic [2:0] cmd);
    add_item(cmd, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
             3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  task automatic add_random_episode();
    int pick;
    int len;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      len = $urandom_range(1, 8);
      add_frame(len, (len == 1 && $urandom_range(0, 3) == 0) ? 9'd0 : 9'(len));
      case ($urandom_range(0, 4))
        0: add_simple(buft_pkg::CMD_CONFIRM);
        1: begin
          repeat ($urandom_range(1, 8)) add_simple(buft_pkg::CMD_TICK);
          add_simple(buft_pkg::CMD_CONFIRM);
        end
        2: begin
          add_simple(buft_pkg::CMD_BYTE);
          add_simple(buft_pkg::CMD_CONFIRM);
        end
        3: add_simple(buft_pkg::CMD_RESET);
        default: ;
      endcase
    end else if (pick == 6) begin
      add_simple(buft_pkg::CMD_ACK);
    end else if (pick == 7) begin
      add_simple(3'($urandom_range(0, 7)));
    end else if (pick == 8) begin
      repeat ($urandom_range(1, 4)) add_simple(buft_pkg::CMD_TICK);
    end else begin
      add_simple($urandom_range(0, 1) ? buft_pkg::CMD_CONFIRM : buft_pkg::CMD_RESET);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || push || expected_results.size() != 0);
    // items without results may still be inside the block
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(buft_pkg::reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      buft_pkg::REG_START_OPCODE:   reg_start = val[7:0];
      buft_pkg::REG_END_OPCODE:     reg_end = val[7:0];
      buft_pkg::REG_OFFSET_OPCODE:  reg_offset = val[7:0];
      buft_pkg::REG_ACK_OPCODE:     reg_ack = val[7:0];
      buft_pkg::REG_COMPACT_MODE:   reg_compact = val[0];
      buft_pkg::REG_WATCHDOG_LIMIT: reg_watchdog = val;
      default: ;
    endcase
  endtask

  task automatic write_settings(logic [7:0] start_code, logic [7:0] end_code,
                                logic [7:0] offset_code, logic [7:0] ack_code,
                                logic compact, logic [15:0] limit);
    write_reg(buft_pkg::REG_START_OPCODE, {8'h00, start_code});
    write_reg(buft_pkg::REG_END_OPCODE, {8'h00, end_code});
    write_reg(buft_pkg::REG_OFFSET_OPCODE, {8'h00, offset_code});
    write_reg(buft_pkg::REG_ACK_OPCODE, {8'h00, ack_code});
    write_reg(buft_pkg::REG_COMPACT_MODE, {15'h0000, compact});
    write_reg(buft_pkg::REG_WATCHDOG_LIMIT, limit);
    settings_used++;
  endtask

  initial begin : stimulus
    int phase_start;
    fr_mode = buft_pkg::MODE_IDLE;
    fr_pos = '0;
    fr_len = '0;
    fr_pending_ack = '0;
    fr_wait = '0;
    reg_start = buft_pkg::START_OPCODE_RST;
    reg_end = buft_pkg::END_OPCODE_RST;
    reg_offset = buft_pkg::OFFSET_OPCODE_RST;
    reg_ack = buft_pkg::ACK_OPCODE_RST;
    reg_compact = buft_pkg::COMPACT_MODE_RST;
    reg_watchdog = buft_pkg::WATCHDOG_LIMIT_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // default registers: acks, zero length, refusal, stray confirm and tick
    add_item(buft_pkg::CMD_ACK, 8'h00, 9'h000, 3'd7, 1'b1);
    add_item(buft_pkg::CMD_ACK, 8'hFF, 9'h1FF, 3'd5, 1'b0);
    add_item(buft_pkg::CMD_BYTE, 8'hFF, 9'd0, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_BYTE, 8'h3C, 9'd5, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_CONFIRM, 8'h00, 9'd0, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_CONFIRM, 8'hFF, 9'h1FF, 3'd7, 1'b1);
    add_item(buft_pkg::CMD_TICK, 8'h00, 9'd0, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_BYTE, 8'h00, 9'd3, 3'd7, 1'b1);
    add_item(buft_pkg::CMD_BYTE, 8'hA5, 9'h1FF, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_BYTE, 8'h5A, 9'h000, 3'd2, 1'b1);
    add_item(buft_pkg::CMD_TICK, 8'h00, 9'd0, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_TICK, 8'h00, 9'd0, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_CONFIRM, 8'h00, 9'd0, 3'd0, 1'b0);
    // reset command in the middle of a frame
    add_item(buft_pkg::CMD_BYTE, 8'h11, 9'd4, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_BYTE, 8'h22, 9'd4, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_RESET, 8'hFF, 9'h1FF, 3'd7, 1'b1);
    add_item(buft_pkg::CMD_BYTE, 8'h33, 9'd2, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_BYTE, 8'h44, 9'd2, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_CONFIRM, 8'h00, 9'd0, 3'd0, 1'b0);
    add_item(3'd5, 8'hFF, 9'h1FF, 3'd7, 1'b1);
    add_item(3'd6, 8'h00, 9'h000, 3'd0, 1'b0);
    add_item(3'd7, 8'h81, 9'h101, 3'd5, 1'b1);
    wait_idle();

    // zero watchdog limit and zero ack opcode, then a long frame past the offset step
    write_settings(8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, 16'd0);
    add_item(buft_pkg::CMD_ACK, 8'h00, 9'd0, 3'd0, 1'b1);
    add_item(buft_pkg::CMD_ACK, 8'h00, 9'd0, 3'd3, 1'b0);
    add_item(buft_pkg::CMD_ACK, 8'h00, 9'd0, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_BYTE, 8'h96, 9'd1, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_TICK, 8'h00, 9'd0, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_ACK, 8'h00, 9'd0, 3'd6, 1'b0);
    add_item(buft_pkg::CMD_TICK, 8'h00, 9'd0, 3'd0, 1'b0);
    add_frame(70, 9'h1FF);
    add_item(buft_pkg::CMD_RESET, 8'h00, 9'd0, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_TICK, 8'h00, 9'd0, 3'd0, 1'b0);
    add_frame(2, 9'd2);
    add_item(buft_pkg::CMD_TICK, 8'h00, 9'd0, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_CONFIRM, 8'h00, 9'd0, 3'd0, 1'b0);
    wait_idle();

    // compact mode: an oversized frame vanishes, a cached ack survives it
    write_settings(8'h55, 8'hAA, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);
    add_item(buft_pkg::CMD_ACK, 8'h00, 9'd0, 3'd2, 1'b0);
    add_frame(65, 9'd65);
    add_item(buft_pkg::CMD_BYTE, 8'hC3, 9'd0, 3'd0, 1'b0);
    repeat (3) add_item(buft_pkg::CMD_TICK, 8'h00, 9'd0, 3'd0, 1'b0);
    add_item(buft_pkg::CMD_CONFIRM, 8'h00, 9'd0, 3'd0, 1'b0);
    add_frame(2, 9'd2);
    add_item(buft_pkg::CMD_CONFIRM, 8'h00, 9'd0, 3'd0, 1'b0);
    wait_idle();

    // random settings, mostly short watchdog limits so timeouts show up
    for (int ph = 0; ph < 3; ph++) begin
      write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                 : 16'($urandom_range(1, 8)));
      if (ph == 2) begin
        @(posedge clk);
        calm <= 1'b1;
      end
      phase_start = items_queued;
      while (items_queued - phase_start < 20) add_random_episode();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d items and %0d results over %0d register settings",
             items_accepted, results_checked, settings_used);
    $display("watchdog timeouts %0d, refused bytes %0d, mismatches %0d",
             timeouts_seen, refusals_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
